// ===== hw/rtl/ecv_pkg.sv =====
// Shared widths, constants and types for the elastic collision velocity block.
`default_nettype none
package ecv_pkg;

  localparam int POS_W   = 20;               // Q16.4 position
  localparam int VEL_W   = 16;               // Q8.8 velocity
  localparam int MASS_W  = 16;
  localparam int RAD_W   = 16;               // Q12.4 radius
  localparam int DP_W    = POS_W + 1;        // position offset
  localparam int DV_W    = VEL_W + 1;        // relative velocity
  localparam int RS_W    = RAD_W + 1;        // radius sum
  localparam int MS_W    = MASS_W + 1;       // mass sum, doubled mass
  localparam int SQ_W    = 2 * DP_W;         // squared offset term
  localparam int PD_W    = DV_W + DP_W;      // dot product term
  localparam int D2_W    = 2 * RS_W;         // |dp|^2 once a hit is known
  localparam int DOT_W   = PD_W + 1;         // full dot product, signed
  localparam int DOTM_W  = 35;               // |dot| bound on a hit
  localparam int DOT_LO  = 18;               // split point of |dot|
  localparam int D2_LO   = 17;               // split point of |dp|^2
  localparam int AB_W    = MS_W + DOTM_W;    // 2*m2*|dot|
  localparam int AB_LO   = AB_W / 2;         // split point of ab
  localparam int DEN_W   = MS_W + D2_W;      // (m1+m2)*|dp|^2
  localparam int NUM_W   = AB_W + DP_W;      // 2*m2*|dot|*|dp_axis|
  localparam int DIV_Q_W = 19;               // quotient bits, |q| < 2^18.5
  localparam int REM_W   = DEN_W + 1;
  localparam int DIV_LAT = DIV_Q_W + 2;      // load, steps, rounding
  localparam int SUM_W   = VEL_W + 5;        // velocity plus signed delta

  localparam logic signed [SUM_W-1:0] VEL_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] VEL_MIN = -SUM_W'(32768);

  // Per-item control and pass-through data that rides beside the dividers
  typedef struct packed {
    logic                    hit;
    logic                    apply;
    logic                    neg_x;
    logic                    neg_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
  } ecv_side_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ecv_div.sv =====
// Pipelined restoring divider with round-half-up of the quotient.
`default_nettype none
module ecv_div
  import ecv_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [NUM_W-1:0]   num,
  input  wire logic [DEN_W-1:0]   den,
  output logic      [DIV_Q_W-1:0] quo
);

  logic [REM_W-1:0]   rem_r [0:DIV_Q_W];
  logic [DIV_Q_W-1:0] low_r [0:DIV_Q_W-1];
  logic [DIV_Q_W-1:0] q_r   [0:DIV_Q_W];
  logic [DEN_W-1:0]   den_r [0:DIV_Q_W];
  logic [DIV_Q_W-1:0] quo_r;
  logic               rnd;

  // Load: the upper part of the numerator is below den when the quotient fits
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num[REM_W+DIV_Q_W-1:DIV_Q_W];
      low_r[0] <= num[DIV_Q_W-1:0];
      q_r[0]   <= '0;
      den_r[0] <= den;
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < DIV_Q_W; k++) begin : g_step
    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    logic           ge;

    assign trial = {rem_r[k], low_r[k][DIV_Q_W-1]};
    assign diff  = trial - {2'b00, den_r[k]};
    assign ge    = trial >= {2'b00, den_r[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        q_r[k+1]   <= {q_r[k][DIV_Q_W-2:0], ge};
        den_r[k+1] <= den_r[k];
      end
    end

    // numerator bits still to be brought down
    if (k < DIV_Q_W - 1) begin : g_low
      always_ff @(posedge clk) begin
        if (en) begin
          low_r[k+1] <= {low_r[k][DIV_Q_W-2:0], 1'b0};
        end
      end
    end
  end

  // Round to nearest, ties up: remainder at least half the divisor
  assign rnd = {rem_r[DIV_Q_W], 1'b0} >= {2'b00, den_r[DIV_Q_W]};

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= q_r[DIV_Q_W] + DIV_Q_W'(rnd);
    end
  end

  assign quo = quo_r;

endmodule
`default_nettype wire

// ===== hw/rtl/elastic_collision_velocity.sv =====
// Top level: 2D elastic collision response for the first of two discs.
`default_nettype none
// One disc pair is accepted per clock when the output is not stalled. On
// its way to the output, seven stages form the offsets, squares, dot
// product, hit test and the wide products (split into partial products),
// then each axis runs through a load stage, a 19-stage restoring divider
// and a rounding stage, and a last stage adds and saturates. A stall on a
// valid output freezes the whole pipeline and raises in_stall; no
// transaction is dropped or repeated. The velocity change is exact and
// rounded once per axis, ties away from zero; results saturate to Q8.8.
module elastic_collision_velocity
  import ecv_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [POS_W-1:0] in_own_pos_x,
  input  wire logic signed [POS_W-1:0] in_own_pos_y,
  input  wire logic signed [VEL_W-1:0] in_own_vel_x,
  input  wire logic signed [VEL_W-1:0] in_own_vel_y,
  input  wire logic signed [POS_W-1:0] in_other_pos_x,
  input  wire logic signed [POS_W-1:0] in_other_pos_y,
  input  wire logic signed [VEL_W-1:0] in_other_vel_x,
  input  wire logic signed [VEL_W-1:0] in_other_vel_y,
  input  wire logic [MASS_W-1:0]       in_own_mass,
  input  wire logic [MASS_W-1:0]       in_other_mass,
  input  wire logic [RAD_W-1:0]        in_own_radius,
  input  wire logic [RAD_W-1:0]        in_other_radius,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [VEL_W-1:0]      out_new_vel_x,
  output logic signed [VEL_W-1:0]      out_new_vel_y,
  output logic                         out_hit
);

  logic en;

  // stage 1: differences and sums
  logic                    s1_v_r;
  logic signed [DP_W-1:0]  s1_dpx_r, s1_dpy_r;
  logic signed [DV_W-1:0]  s1_dvx_r, s1_dvy_r;
  logic [RS_W-1:0]         s1_rs_r;
  logic [MS_W-1:0]         s1_msum_r, s1_m2x2_r;
  logic signed [VEL_W-1:0] s1_vx_r, s1_vy_r;

  // stage 2: squares and products
  logic                    s2_v_r;
  logic signed [SQ_W-1:0]  s2_sqx_r, s2_sqy_r;
  logic signed [PD_W-1:0]  s2_pdx_r, s2_pdy_r;
  logic [D2_W-1:0]         s2_rs2_r;
  logic signed [DP_W-1:0]  s2_dpx_r, s2_dpy_r;
  logic [MS_W-1:0]         s2_msum_r, s2_m2x2_r;
  logic signed [VEL_W-1:0] s2_vx_r, s2_vy_r;

  // stage 3: hit test and magnitudes
  logic                    s3_v_r;
  ecv_side_t               s3_side_r;
  logic [D2_W-1:0]         s3_d2_r;
  logic [DOTM_W-1:0]       s3_dotm_r;
  logic [DP_W-1:0]         s3_dpxm_r, s3_dpym_r;
  logic [MS_W-1:0]         s3_msum_r, s3_m2x2_r;
  logic [SQ_W:0]           s3_d2_nxt;
  logic signed [DOT_W-1:0] s3_dot_nxt;
  logic [DOT_W-1:0]        s3_dotm_nxt;

  // stage 4: partial products
  logic                    s4_v_r;
  ecv_side_t               s4_side_r;
  logic [MS_W+DOT_LO-1:0]  s4_pp_lo_r;
  logic [AB_W-DOT_LO-1:0]  s4_pp_hi_r;
  logic [MS_W+D2_LO-1:0]   s4_den_lo_r;
  logic [DEN_W-D2_LO-1:0]  s4_den_hi_r;
  logic [DP_W-1:0]         s4_dpxm_r, s4_dpym_r;

  // stage 5: combine to ab and den
  logic                    s5_v_r;
  ecv_side_t               s5_side_r;
  logic [AB_W-1:0]         s5_ab_r;
  logic [DEN_W-1:0]        s5_den_r;
  logic [DP_W-1:0]         s5_dpxm_r, s5_dpym_r;

  // stage 6: numerator partial products
  logic                         s6_v_r;
  ecv_side_t                    s6_side_r;
  logic [AB_LO+DP_W-1:0]        s6_nxl_r, s6_nyl_r;
  logic [AB_W-AB_LO+DP_W-1:0]   s6_nxh_r, s6_nyh_r;
  logic [DEN_W-1:0]             s6_den_r;

  // stage 7: numerators
  logic                    s7_v_r;
  ecv_side_t               s7_side_r;
  logic [NUM_W-1:0]        s7_numx_r, s7_numy_r;
  logic [DEN_W-1:0]        s7_den_r;

  // divider sideband and output
  logic                    dv_v_r    [0:DIV_LAT-1];
  ecv_side_t               dv_side_r [0:DIV_LAT-1];
  logic [DIV_Q_W-1:0]      qx, qy;
  ecv_side_t               fin;
  logic signed [DIV_Q_W:0] dlx, dly;
  logic signed [SUM_W-1:0] sumx, sumy;
  logic signed [VEL_W-1:0] nvx, nvy;
  logic                    out_valid_r, out_hit_r;
  logic signed [VEL_W-1:0] out_vx_r, out_vy_r;

  // whole pipeline advances unless a held result is stalled
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) dv_v_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
      dv_v_r[0] <= s7_v_r;
      for (int k = 1; k < DIV_LAT; k++) dv_v_r[k] <= dv_v_r[k-1];
      out_valid_r <= dv_v_r[DIV_LAT-1];
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (en) begin
      s1_dpx_r  <= DP_W'(in_own_pos_x) - DP_W'(in_other_pos_x);
      s1_dpy_r  <= DP_W'(in_own_pos_y) - DP_W'(in_other_pos_y);
      s1_dvx_r  <= DV_W'(in_own_vel_x) - DV_W'(in_other_vel_x);
      s1_dvy_r  <= DV_W'(in_own_vel_y) - DV_W'(in_other_vel_y);
      s1_rs_r   <= RS_W'(in_own_radius) + RS_W'(in_other_radius);
      s1_msum_r <= MS_W'(in_own_mass) + MS_W'(in_other_mass);
      s1_m2x2_r <= {in_other_mass, 1'b0};
      s1_vx_r   <= in_own_vel_x;
      s1_vy_r   <= in_own_vel_y;
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (en) begin
      s2_sqx_r  <= SQ_W'(s1_dpx_r) * SQ_W'(s1_dpx_r);
      s2_sqy_r  <= SQ_W'(s1_dpy_r) * SQ_W'(s1_dpy_r);
      s2_pdx_r  <= PD_W'(s1_dvx_r) * PD_W'(s1_dpx_r);
      s2_pdy_r  <= PD_W'(s1_dvy_r) * PD_W'(s1_dpy_r);
      s2_rs2_r  <= D2_W'(s1_rs_r) * D2_W'(s1_rs_r);
      s2_dpx_r  <= s1_dpx_r;
      s2_dpy_r  <= s1_dpy_r;
      s2_msum_r <= s1_msum_r;
      s2_m2x2_r <= s1_m2x2_r;
      s2_vx_r   <= s1_vx_r;
      s2_vy_r   <= s1_vy_r;
    end
  end

  // stage 3: hit needs overlap and approaching motion
  assign s3_d2_nxt   = (SQ_W+1)'(unsigned'(s2_sqx_r)) + (SQ_W+1)'(unsigned'(s2_sqy_r));
  assign s3_dot_nxt  = DOT_W'(s2_pdx_r) + DOT_W'(s2_pdy_r);
  assign s3_dotm_nxt = s3_dot_nxt[DOT_W-1] ? DOT_W'(-s3_dot_nxt) : DOT_W'(s3_dot_nxt);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r.hit   <= (s3_d2_nxt <= (SQ_W+1)'(s2_rs2_r)) && s3_dot_nxt[DOT_W-1];
      s3_side_r.apply <= (s3_d2_nxt <= (SQ_W+1)'(s2_rs2_r)) && s3_dot_nxt[DOT_W-1]
                         && (s2_msum_r != '0);
      s3_side_r.neg_x <= s2_dpx_r[DP_W-1];
      s3_side_r.neg_y <= s2_dpy_r[DP_W-1];
      s3_side_r.vel_x <= s2_vx_r;
      s3_side_r.vel_y <= s2_vy_r;
      s3_d2_r   <= s3_d2_nxt[D2_W-1:0];
      s3_dotm_r <= s3_dotm_nxt[DOTM_W-1:0];
      s3_dpxm_r <= s2_dpx_r[DP_W-1] ? DP_W'(-s2_dpx_r) : DP_W'(s2_dpx_r);
      s3_dpym_r <= s2_dpy_r[DP_W-1] ? DP_W'(-s2_dpy_r) : DP_W'(s2_dpy_r);
      s3_msum_r <= s2_msum_r;
      s3_m2x2_r <= s2_m2x2_r;
    end
  end

  // stage 4
  always_ff @(posedge clk) begin
    if (en) begin
      s4_side_r   <= s3_side_r;
      s4_pp_lo_r  <= (MS_W+DOT_LO)'(s3_m2x2_r) * (MS_W+DOT_LO)'(s3_dotm_r[DOT_LO-1:0]);
      s4_pp_hi_r  <= (AB_W-DOT_LO)'(s3_m2x2_r)
                     * (AB_W-DOT_LO)'(s3_dotm_r[DOTM_W-1:DOT_LO]);
      s4_den_lo_r <= (MS_W+D2_LO)'(s3_msum_r) * (MS_W+D2_LO)'(s3_d2_r[D2_LO-1:0]);
      s4_den_hi_r <= (DEN_W-D2_LO)'(s3_msum_r) * (DEN_W-D2_LO)'(s3_d2_r[D2_W-1:D2_LO]);
      s4_dpxm_r   <= s3_dpxm_r;
      s4_dpym_r   <= s3_dpym_r;
    end
  end

  // stage 5
  always_ff @(posedge clk) begin
    if (en) begin
      s5_side_r <= s4_side_r;
      s5_ab_r   <= AB_W'(s4_pp_lo_r) + {s4_pp_hi_r, DOT_LO'(0)};
      s5_den_r  <= DEN_W'(s4_den_lo_r) + {s4_den_hi_r, D2_LO'(0)};
      s5_dpxm_r <= s4_dpxm_r;
      s5_dpym_r <= s4_dpym_r;
    end
  end

  // stage 6
  always_ff @(posedge clk) begin
    if (en) begin
      s6_side_r <= s5_side_r;
      s6_nxl_r  <= (AB_LO+DP_W)'(s5_ab_r[AB_LO-1:0]) * (AB_LO+DP_W)'(s5_dpxm_r);
      s6_nyl_r  <= (AB_LO+DP_W)'(s5_ab_r[AB_LO-1:0]) * (AB_LO+DP_W)'(s5_dpym_r);
      s6_nxh_r  <= (AB_W-AB_LO+DP_W)'(s5_ab_r[AB_W-1:AB_LO])
                   * (AB_W-AB_LO+DP_W)'(s5_dpxm_r);
      s6_nyh_r  <= (AB_W-AB_LO+DP_W)'(s5_ab_r[AB_W-1:AB_LO])
                   * (AB_W-AB_LO+DP_W)'(s5_dpym_r);
      s6_den_r  <= s5_den_r;
    end
  end

  // stage 7
  always_ff @(posedge clk) begin
    if (en) begin
      s7_side_r <= s6_side_r;
      s7_numx_r <= NUM_W'(s6_nxl_r) + {s6_nxh_r, AB_LO'(0)};
      s7_numy_r <= NUM_W'(s6_nyl_r) + {s6_nyh_r, AB_LO'(0)};
      s7_den_r  <= s6_den_r;
    end
  end

  // one divider per axis
  ecv_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (s7_numx_r),
    .den (s7_den_r),
    .quo (qx)
  );

  ecv_div u_div_y (
    .clk (clk),
    .en  (en),
    .num (s7_numy_r),
    .den (s7_den_r),
    .quo (qy)
  );

  // sideband follows the divider latency
  always_ff @(posedge clk) begin
    if (en) begin
      dv_side_r[0] <= s7_side_r;
      for (int k = 1; k < DIV_LAT; k++) dv_side_r[k] <= dv_side_r[k-1];
    end
  end

  // apply signed change and saturate
  assign fin  = dv_side_r[DIV_LAT-1];
  assign dlx  = !fin.apply ? '0 :
                fin.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign dly  = !fin.apply ? '0 :
                fin.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
  assign sumx = SUM_W'(fin.vel_x) + SUM_W'(dlx);
  assign sumy = SUM_W'(fin.vel_y) + SUM_W'(dly);
  assign nvx  = (sumx > VEL_MAX) ? VEL_MAX[VEL_W-1:0] :
                (sumx < VEL_MIN) ? VEL_MIN[VEL_W-1:0] : sumx[VEL_W-1:0];
  assign nvy  = (sumy > VEL_MAX) ? VEL_MAX[VEL_W-1:0] :
                (sumy < VEL_MIN) ? VEL_MIN[VEL_W-1:0] : sumy[VEL_W-1:0];

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_vx_r  <= nvx;
      out_vy_r  <= nvy;
      out_hit_r <= fin.hit;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_vel_x = out_vx_r;
  assign out_new_vel_y = out_vy_r;
  assign out_hit       = out_hit_r;

endmodule
`default_nettype wire

// ===== hw/rtl/ecv_checker.sv =====
// Port-level checker for the elastic collision velocity block, with its bind.
`default_nettype none
module ecv_checker
  import ecv_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic signed [VEL_W-1:0] out_new_vel_x,
  input wire logic signed [VEL_W-1:0] out_new_vel_y,
  input wire logic                    out_hit
);

  // nothing is presented in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result presented right after reset");

  // input only backs up when a held result is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without an output stall");

  // a stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_new_vel_x)
      && $stable(out_new_vel_y) && $stable(out_hit)))
    else $error("stalled result changed");

  // a free output lets the input in on the same edge
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while the output is free");

endmodule

bind elastic_collision_velocity ecv_checker u_ecv_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_new_vel_x (out_new_vel_x),
  .out_new_vel_y (out_new_vel_y),
  .out_hit       (out_hit)
);
`default_nettype wire

// ===== tb/sv/elastic_collision_velocity_tb.sv =====
// Testbench for the elastic collision velocity block: directed and random disc pairs checked against a predictor.
`default_nettype none
module elastic_collision_velocity_tb
  import ecv_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [POS_W-1:0] own_px, own_py, oth_px, oth_py;
    logic signed [VEL_W-1:0] own_vx, own_vy, oth_vx, oth_vy;
    logic [MASS_W-1:0]       own_m, oth_m;
    logic [RAD_W-1:0]        own_r, oth_r;
  } disc_pair_t;

  typedef struct {
    logic signed [VEL_W-1:0] vx, vy;
    logic                    hit;
  } bounce_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [POS_W-1:0] in_own_pos_x = '0, in_own_pos_y = '0;
  logic signed [POS_W-1:0] in_other_pos_x = '0, in_other_pos_y = '0;
  logic signed [VEL_W-1:0] in_own_vel_x = '0, in_own_vel_y = '0;
  logic signed [VEL_W-1:0] in_other_vel_x = '0, in_other_vel_y = '0;
  logic [MASS_W-1:0] in_own_mass = '0, in_other_mass = '0;
  logic [RAD_W-1:0] in_own_radius = '0, in_other_radius = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VEL_W-1:0] out_new_vel_x, out_new_vel_y;
  logic out_hit;

  disc_pair_t pending_pairs[$];
  bounce_t    expected_bounces[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int mismatches = 0;
  int n_sent = 0, n_checked = 0, n_hits = 0;

  always #1 clk = ~clk;

  elastic_collision_velocity u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_own_pos_x(in_own_pos_x), .in_own_pos_y(in_own_pos_y),
    .in_own_vel_x(in_own_vel_x), .in_own_vel_y(in_own_vel_y),
    .in_other_pos_x(in_other_pos_x), .in_other_pos_y(in_other_pos_y),
    .in_other_vel_x(in_other_vel_x), .in_other_vel_y(in_other_vel_y),
    .in_own_mass(in_own_mass), .in_other_mass(in_other_mass),
    .in_own_radius(in_own_radius), .in_other_radius(in_other_radius),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_new_vel_x(out_new_vel_x), .out_new_vel_y(out_new_vel_y),
    .out_hit(out_hit)
  );

  function automatic logic signed [VEL_W-1:0] clamp_vel(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[VEL_W-1:0];
  endfunction

  // Exact impulse per axis, rounded to nearest with ties away from zero
  function automatic bounce_t predict_bounce(disc_pair_t p);
    longint dpx, dpy, dvx, dvy, d2, rs, dot, nx, ny, qx, qy;
    logic [127:0] den, ab, num, q, r;
    bounce_t b;
    dpx = longint'(p.own_px) - longint'(p.oth_px);
    dpy = longint'(p.own_py) - longint'(p.oth_py);
    dvx = longint'(p.own_vx) - longint'(p.oth_vx);
    dvy = longint'(p.own_vy) - longint'(p.oth_vy);
    d2 = dpx * dpx + dpy * dpy;
    rs = longint'(p.own_r) + longint'(p.oth_r);
    dot = dvx * dpx + dvy * dpy;
    b.hit = (d2 <= rs * rs) && (dot < 0);
    nx = p.own_vx;
    ny = p.own_vy;
    if (b.hit && (p.own_m + 17'(p.oth_m)) != 0) begin
      den = 128'(longint'(p.own_m) + longint'(p.oth_m)) * 128'(d2);
      ab = 128'(2) * 128'(p.oth_m) * 128'(-dot);
      num = ab * 128'(dpx < 0 ? -dpx : dpx);
      q = num / den;
      r = num % den;
      if (r >= den - r) q = q + 1;
      qx = longint'(q);
      num = ab * 128'(dpy < 0 ? -dpy : dpy);
      q = num / den;
      r = num % den;
      if (r >= den - r) q = q + 1;
      qy = longint'(q);
      nx = nx + (dpx < 0 ? -qx : qx);
      ny = ny + (dpy < 0 ? -qy : qy);
    end
    b.vx = clamp_vel(nx);
    b.vy = clamp_vel(ny);
    return b;
  endfunction

  // Driver: offer a new pair, unless idling at random, whenever the last one was taken or none is up
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_bounces.push_back(predict_bounce('{in_own_pos_x, in_own_pos_y,
        in_other_pos_x, in_other_pos_y, in_own_vel_x, in_own_vel_y,
        in_other_vel_x, in_other_vel_y, in_own_mass, in_other_mass,
        in_own_radius, in_other_radius}));
      n_sent++;
    end
    if (rst_n && (!in_valid || !in_stall)) begin
      if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        disc_pair_t p;
        p = pending_pairs.pop_front();
        in_valid <= 1'b1;
        in_own_pos_x <= p.own_px;   in_own_pos_y <= p.own_py;
        in_other_pos_x <= p.oth_px; in_other_pos_y <= p.oth_py;
        in_own_vel_x <= p.own_vx;   in_own_vel_y <= p.own_vy;
        in_other_vel_x <= p.oth_vx; in_other_vel_y <= p.oth_vy;
        in_own_mass <= p.own_m;     in_other_mass <= p.oth_m;
        in_own_radius <= p.own_r;   in_other_radius <= p.oth_r;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bounces.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result vx=%0d vy=%0d hit=%0b",
                   out_new_vel_x, out_new_vel_y, out_hit);
      end else begin
        bounce_t e;
        e = expected_bounces.pop_front();
        n_checked++;
        if (e.hit) n_hits++;
        if (out_new_vel_x !== e.vx || out_new_vel_y !== e.vy || out_hit !== e.hit) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp vx=%0d vy=%0d hit=%0b, got vx=%0d vy=%0d hit=%0b",
                     n_checked, e.vx, e.vy, e.hit, out_new_vel_x, out_new_vel_y, out_hit);
        end
      end
    end
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  function automatic disc_pair_t mk_pair(int opx, int opy, int ovx, int ovy,
      int tpx, int tpy, int tvx, int tvy, int m1, int m2, int r1, int r2);
    disc_pair_t p;
    p.own_px = POS_W'(opx); p.own_py = POS_W'(opy);
    p.own_vx = VEL_W'(ovx); p.own_vy = VEL_W'(ovy);
    p.oth_px = POS_W'(tpx); p.oth_py = POS_W'(tpy);
    p.oth_vx = VEL_W'(tvx); p.oth_vy = VEL_W'(tvy);
    p.own_m = MASS_W'(m1); p.oth_m = MASS_W'(m2);
    p.own_r = RAD_W'(r1); p.oth_r = RAD_W'(r2);
    return p;
  endfunction

  // Mostly close pairs so the hit path gets real traffic, some pure noise
  function automatic disc_pair_t random_pair();
    disc_pair_t p;
    int span;
    p.oth_px = POS_W'($urandom); p.oth_py = POS_W'($urandom);
    p.own_vx = VEL_W'($urandom); p.own_vy = VEL_W'($urandom);
    p.oth_vx = VEL_W'($urandom); p.oth_vy = VEL_W'($urandom);
    p.own_m = MASS_W'(($urandom_range(3) == 0) ? $urandom_range(1, 8)
                                               : $urandom_range(1, 65535));
    p.oth_m = MASS_W'(($urandom_range(3) == 0) ? $urandom_range(1, 8)
                                               : $urandom_range(1, 65535));
    if ($urandom_range(4) == 0) begin
      p.own_r = RAD_W'($urandom_range(1, 65535));
      p.oth_r = RAD_W'($urandom_range(1, 65535));
    end else begin
      p.own_r = RAD_W'($urandom_range(1, 2000));
      p.oth_r = RAD_W'($urandom_range(1, 2000));
    end
    if ($urandom_range(9) < 7) begin
      span = int'(p.own_r) + int'(p.oth_r);
      p.own_px = p.oth_px + POS_W'($urandom_range(0, 2 * span) - span);
      p.own_py = p.oth_py + POS_W'($urandom_range(0, 2 * span) - span);
      // Small velocities keep the result inside range most of the time
      if ($urandom_range(1) == 0) begin
        p.own_vx = VEL_W'($urandom_range(0, 4095) - 2048);
        p.own_vy = VEL_W'($urandom_range(0, 4095) - 2048);
        p.oth_vx = VEL_W'($urandom_range(0, 4095) - 2048);
        p.oth_vy = VEL_W'($urandom_range(0, 4095) - 2048);
      end
    end else begin
      p.own_px = POS_W'($urandom); p.own_py = POS_W'($urandom);
    end
    return p;
  endfunction

  task automatic drain_phase();
    while (pending_pairs.size() > 0 || expected_bounces.size() > 0 || in_valid)
      @(posedge clk);
  endtask

  // Stimulus: directed corners first, then random pairs over idle phases
  initial begin
    int idle_set[4] = '{0, 75, 0, 34};
    int stall_set[4] = '{0, 0, 75, 34};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // far apart at the position extremes
    pending_pairs.push_back(mk_pair(524287, 524287, 32767, 32767,
      -524288, -524288, -32768, -32768, 65535, 65535, 65535, 65535));
    pending_pairs.push_back(mk_pair(-524288, 0, -32768, 0, 524287, 0, 32767, 0, 1, 1, 1, 1));
    // coincident centres
    pending_pairs.push_back(mk_pair(100, 100, 256, -256, 100, 100, -256, 256, 3, 5, 16, 16));
    // both masses zero on a hit
    pending_pairs.push_back(mk_pair(0, 0, 256, 0, 20, 0, -256, 0, 0, 0, 16, 16));
    // zero radii, touching only at the same point
    pending_pairs.push_back(mk_pair(0, 0, 256, 0, 1, 0, -256, 0, 7, 7, 0, 0));
    // head-on, equal masses: velocities swap
    pending_pairs.push_back(mk_pair(0, 0, 256, 0, 30, 0, -256, 0, 10, 10, 16, 16));
    pending_pairs.push_back(mk_pair(0, 0, 0, 512, 0, 30, 0, -512, 10, 10, 16, 16));
    // separating pair inside radius: no hit
    pending_pairs.push_back(mk_pair(0, 0, -256, 0, 30, 0, 256, 0, 10, 10, 16, 16));
    // saturation both ways
    pending_pairs.push_back(mk_pair(0, 0, 32767, 32767, 10, 10, -32768, -32768,
      1, 65535, 65535, 65535));
    pending_pairs.push_back(mk_pair(10, 10, -32768, -32768, 0, 0, 32767, 32767,
      1, 65535, 65535, 65535));
    // glancing, oblique, exactly on the radius sum
    pending_pairs.push_back(mk_pair(0, 0, 300, 0, 20, 28, -100, 0, 3, 9, 20, 20));
    pending_pairs.push_back(mk_pair(-7, 13, 77, -55, 29, -11, -3, 91, 65535, 1, 22, 21));
    pending_pairs.push_back(mk_pair(0, 0, 1, 0, 3, 4, 0, 0, 1, 1, 3, 2));
    pending_pairs.push_back(mk_pair(524287, -524288, 32767, -32768, 524286, -524287,
      -32768, 32767, 65535, 65535, 1, 1));
    drain_phase();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_set[ph];
      recv_stall_pct = stall_set[ph];
      repeat (410) pending_pairs.push_back(random_pair());
      drain_phase();
    end
    repeat (60) @(posedge clk);
    $display("checked %0d collision results (%0d hits, %0d misses) over four idle phases",
             n_checked, n_hits, n_checked - n_hits);
    if (mismatches == 0 && expected_bounces.size() == 0 && n_checked == n_sent) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_bounces.size());
      $display("tb: failure");
    end
    $finish;
  end

  // Long receiver hold-off early in the first random phase to fill the pipe
  initial begin
    while (n_sent < 100) @(posedge clk);
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", expected_bounces.size());
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/ecv_pkg.sv
hw/rtl/ecv_div.sv
hw/rtl/elastic_collision_velocity.sv
hw/rtl/ecv_checker.sv
tb/sv/elastic_collision_velocity_tb.sv
